// ===== rtl/core/b64se_pkg.sv =====
// Shared types, constants and the alphabet function for the base64 stream encoder.
`default_nettype none
package b64se_pkg;

   localparam int unsigned ByteBits   = 8;
   localparam int unsigned GroupBits  = 24;
   localparam int unsigned SextetBits = 6;
   localparam int unsigned CharBits   = 7;
   localparam int unsigned HeldBits   = GroupBits - ByteBits;
   localparam int unsigned SextetsPerGroup = GroupBits / SextetBits;
   localparam int unsigned SxIdxBits  = $clog2(SextetsPerGroup);

   localparam logic [SxIdxBits-1:0] SxFirst = '0;
   localparam logic [SxIdxBits-1:0] SxLast  = SxIdxBits'(SextetsPerGroup - 1);

   // Held byte count codes
   localparam logic [1:0] HeldNone = 2'd0;
   localparam logic [1:0] HeldOne  = 2'd1;

   // One complete 24-bit group handed from packer to emitter
   typedef struct packed {
      logic [GroupBits-1:0] bits;
      logic                 fin;
   } grp_type;

   // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [CharBits-1:0] sextet_to_char(input logic [SextetBits-1:0] idx);
      logic [CharBits-1:0] code;
      if (idx < 6'd26) begin
         code = 7'h41 + {1'b0, idx};
      end else if (idx < 6'd52) begin
         code = 7'h61 + {1'b0, idx - 6'd26};
      end else if (idx < 6'd62) begin
         code = 7'h30 + {1'b0, idx - 6'd52};
      end else if (idx == 6'd62) begin
         code = 7'h2B;
      end else begin
         code = 7'h2F;
      end
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b64se_pack.sv =====
// Byte packer: holds up to two bytes and forms a zero-filled 24-bit group.
`default_nettype none
module b64se_pack (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [b64se_pkg::ByteBits-1:0]     req_data_byte,
   input  wire logic                               req_final_byte,
   output logic                                    grp_valid,
   input  wire logic                               grp_ready,
   output b64se_pkg::grp_type                      grp
);

   logic [b64se_pkg::HeldBits-1:0] held_ff, held_in;
   logic [1:0]                     cnt_ff, cnt_in;
   logic                           closes;
   logic                           xfer;

   // A byte closes the group when two are held or it ends the message
   assign closes    = req_final_byte || !((cnt_ff == b64se_pkg::HeldNone) ||
                                          (cnt_ff == b64se_pkg::HeldOne));
   assign req_ready = closes ? grp_ready : 1'b1;
   assign grp_valid = req_valid && closes;
   assign xfer      = req_valid && req_ready;

   always_comb begin
      case (cnt_ff)
         b64se_pkg::HeldNone: grp.bits = {req_data_byte, 16'h0000};
         b64se_pkg::HeldOne:  grp.bits = {held_ff[7:0], req_data_byte, 8'h00};
         default:             grp.bits = {held_ff, req_data_byte};
      endcase
      grp.fin = req_final_byte;
   end

   always_comb begin
      held_in = held_ff;
      cnt_in  = cnt_ff;
      if (xfer) begin
         if (closes) begin
            cnt_in = b64se_pkg::HeldNone;
         end else begin
            held_in = {held_ff[7:0], req_data_byte};
            cnt_in  = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         cnt_ff <= b64se_pkg::HeldNone;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/b64se_emit.sv =====
// Group emitter: steps through four sextets and registers one character per transfer.
`default_nettype none
module b64se_emit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               grp_valid,
   output logic                                    grp_ready,
   input  wire b64se_pkg::grp_type                 grp,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [b64se_pkg::CharBits-1:0]          rsp_char_code,
   output logic                                    rsp_group_last,
   output logic                                    rsp_message_last
);

   logic                                  gv_ff, gv_in;
   b64se_pkg::grp_type                    g_ff, g_in;
   logic [b64se_pkg::SxIdxBits-1:0]       sx_ff, sx_in;
   logic                                  ov_ff, ov_in;
   logic [b64se_pkg::CharBits-1:0]        ch_ff, ch_in;
   logic                                  gl_ff, gl_in;
   logic                                  ml_ff, ml_in;
   logic                                  advance;
   logic                                  at_last;
   logic [b64se_pkg::SextetBits-1:0]      sextet;

   assign advance   = gv_ff && (!ov_ff || rsp_ready);
   assign at_last   = (sx_ff == b64se_pkg::SxLast);
   assign grp_ready = !gv_ff || (advance && at_last);

   always_comb begin
      case (sx_ff)
         2'd0:    sextet = g_ff.bits[23:18];
         2'd1:    sextet = g_ff.bits[17:12];
         2'd2:    sextet = g_ff.bits[11:6];
         default: sextet = g_ff.bits[5:0];
      endcase
   end

   always_comb begin
      gv_in = gv_ff;
      g_in  = g_ff;
      sx_in = sx_ff;
      ov_in = ov_ff;
      ch_in = ch_ff;
      gl_in = gl_ff;
      ml_in = ml_ff;
      if (rsp_ready) begin
         ov_in = 1'b0;
      end
      if (advance) begin
         ov_in = 1'b1;
         ch_in = b64se_pkg::sextet_to_char(sextet);
         gl_in = at_last;
         ml_in = at_last && g_ff.fin;
         if (at_last) begin
            gv_in = 1'b0;
            sx_in = b64se_pkg::SxFirst;
         end else begin
            sx_in = sx_ff + b64se_pkg::SxIdxBits'(1);
         end
      end
      if (grp_valid && grp_ready) begin
         gv_in = 1'b1;
         g_in  = grp;
         sx_in = b64se_pkg::SxFirst;
      end
   end

   always_ff @(posedge clock) begin
      g_ff  <= g_in;
      ch_ff <= ch_in;
      gl_ff <= gl_in;
      ml_ff <= ml_in;
      if (reset) begin
         gv_ff <= 1'b0;
         sx_ff <= b64se_pkg::SxFirst;
         ov_ff <= 1'b0;
      end else begin
         gv_ff <= gv_in;
         sx_ff <= sx_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_char_code    = ch_ff;
   assign rsp_group_last   = gl_ff;
   assign rsp_message_last = ml_ff;

endmodule
`default_nettype wire

// ===== rtl/core/base64_stream_encoder.sv =====
// Top level of the base64 stream encoder: byte packer feeding the group emitter.
// The byte that closes a group is registered in the group register, then its first character
// in the result register. Throughput: one byte transfer per cycle while a group is open; the
// single-character result register gives one character per cycle while rsp_ready is high.
// The group register is refilled in the cycle its fourth character moves out, so no bubbles.
// Reset (synchronous, active high) empties the held bytes, the group register and the output.
`default_nettype none
module base64_stream_encoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [b64se_pkg::ByteBits-1:0]     req_data_byte,
   input  wire logic                               req_final_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [b64se_pkg::CharBits-1:0]          rsp_char_code,
   output logic                                    rsp_group_last,
   output logic                                    rsp_message_last
);

   // Completed group between packer and emitter
   logic               grp_valid;
   logic               grp_ready;
   b64se_pkg::grp_type grp;

   // Packer: bytes that do not close a group are always taken; a closing byte
   // waits only for the emitter's group register to be free.
   b64se_pack u_pack (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .grp_valid      (grp_valid),
      .grp_ready      (grp_ready),
      .grp            (grp)
   );

   // Emitter: four characters per group, most significant sextet first,
   // with group and message end flags on the fourth.
   b64se_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .grp_valid        (grp_valid),
      .grp_ready        (grp_ready),
      .grp              (grp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_code    (rsp_char_code),
      .rsp_group_last   (rsp_group_last),
      .rsp_message_last (rsp_message_last)
   );

endmodule
`default_nettype wire
